// ===== hdl/pibcaw_pkg.sv =====
// Shared types and constants for the PI regulator with back-calculation anti-windup.
// Holds the codes and controller/datapath command structs; it depends on nothing else.
package pibcaw_pkg;

   localparam int DEFAULT_SIGNAL_WIDTH  = 16;
   localparam int DEFAULT_FRACTION_BITS = 16;

   // Fixed field widths.
   localparam int GAIN_WIDTH     = 16;
   localparam int RAW_WIDTH      = 25;
   localparam int OP_WIDTH       = 2;
   localparam int STATUS_WIDTH   = 2;
   localparam int CSR_INDEX_W    = 3;
   localparam int ACC_GUARD_BITS = 8;
   // Fraction bits of kp (Q8.8) and of the Q0.16 step gains.
   localparam int KP_FRAC_BITS   = 8;
   localparam int STEP_FRAC_BITS = 16;

   localparam logic [OP_WIDTH-1:0] OP_UPDATE = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_TRACK  = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_RESET  = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_INVALID  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_STEP = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDUP_STEP   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_LOW     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_HIGH    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_I,
      ST_MUL_W,
      ST_TRK_MUL,
      ST_FINISH
   } ctrl_state_type;

   // Operand pair for the shared multiplier.
   typedef enum logic [1:0] {
      MUL_PROP,
      MUL_INTEG,
      MUL_WINDUP_UPD,
      MUL_WINDUP_TRK
   } mul_sel_type;

   // How a request is retired.
   typedef enum logic [2:0] {
      FIN_NONE,
      FIN_UPDATE,
      FIN_TRACK_ACC,
      FIN_TRACK_SET,
      FIN_RESET,
      FIN_INVALID,
      FIN_NOP
   } fin_kind_type;

   typedef struct packed {
      logic         capture;
      logic         mul_en;
      mul_sel_type  mul_sel;
      logic         latch_sum;
      logic         load_acc;
      logic         add_term;
      fin_kind_type finish;
   } dp_cmd_type;

   typedef struct packed {
      logic limits_invalid;
      logic windup_zero;
   } dp_status_type;

endpackage

// ===== hdl/pibcaw_if.sv =====
// Request and response channel interfaces of the PI regulator.
// Valid/ready handshake with payload; depends on nothing but plain logic types.
interface pibcaw_req_if #(parameter int SIGNAL_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic [1:0]                     operation;
   logic signed [SIGNAL_WIDTH-1:0] sample_value;

   modport source (output valid, output operation, output sample_value, input ready);
   modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

interface pibcaw_rsp_if #(parameter int SIGNAL_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SIGNAL_WIDTH-1:0] drive_value;
   logic signed [24:0]             raw_drive;
   logic [1:0]                     status;

   modport source (output valid, output drive_value, output raw_drive, output status,
                   input ready);
   modport sink   (input valid, input drive_value, input raw_drive, input status,
                   output ready);
endinterface

// ===== hdl/pibcaw_regs.sv =====
// Configuration register file of the PI regulator: gains and output limits.
// Uses pibcaw_pkg for register indexes and field widths.
module pibcaw_regs
   import pibcaw_pkg::*;
#(
   parameter int SIGNAL_WIDTH = DEFAULT_SIGNAL_WIDTH,
   parameter int CSR_DATA_W   = GAIN_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_write_data,
   output logic [GAIN_WIDTH-1:0]          prop_gain,
   output logic [GAIN_WIDTH-1:0]          integral_step,
   output logic [GAIN_WIDTH-1:0]          windup_step,
   output logic signed [SIGNAL_WIDTH-1:0] limit_low,
   output logic signed [SIGNAL_WIDTH-1:0] limit_high
);

   logic [GAIN_WIDTH-1:0]          prop_gain_ff;
   logic [GAIN_WIDTH-1:0]          integral_step_ff;
   logic [GAIN_WIDTH-1:0]          windup_step_ff;
   logic signed [SIGNAL_WIDTH-1:0] limit_low_ff;
   logic signed [SIGNAL_WIDTH-1:0] limit_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integral_step_ff <= '0;
         windup_step_ff   <= '0;
         limit_low_ff     <= {1'b1, {(SIGNAL_WIDTH-1){1'b0}}};
         limit_high_ff    <= {1'b0, {(SIGNAL_WIDTH-1){1'b1}}};
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PROP_GAIN:     prop_gain_ff     <= csr_write_data[GAIN_WIDTH-1:0];
            CSR_INTEGRAL_STEP: integral_step_ff <= csr_write_data[GAIN_WIDTH-1:0];
            CSR_WINDUP_STEP:   windup_step_ff   <= csr_write_data[GAIN_WIDTH-1:0];
            CSR_LIMIT_LOW:     limit_low_ff     <= csr_write_data[SIGNAL_WIDTH-1:0];
            CSR_LIMIT_HIGH:    limit_high_ff    <= csr_write_data[SIGNAL_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign prop_gain     = prop_gain_ff;
   assign integral_step = integral_step_ff;
   assign windup_step   = windup_step_ff;
   assign limit_low     = limit_low_ff;
   assign limit_high    = limit_high_ff;

endmodule

// ===== hdl/pibcaw_ctrl.sv =====
// Sequencing controller of the PI regulator: request intake, multiplier schedule
// and response valid. Uses pibcaw_pkg for state, command and status types.
module pibcaw_ctrl
   import pibcaw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OP_WIDTH-1:0] req_operation,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dp_status_type       dp_status,
   output dp_cmd_type          dp_cmd
);

   ctrl_state_type state_ff, state_in;
   fin_kind_type   fin_kind_ff, fin_kind_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fin_kind_ff  <= FIN_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_kind_ff  <= fin_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      fin_kind_in       = fin_kind_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      req_ready         = 1'b0;
      dp_cmd.capture    = 1'b0;
      dp_cmd.mul_en     = 1'b0;
      dp_cmd.mul_sel    = MUL_PROP;
      dp_cmd.latch_sum  = 1'b0;
      dp_cmd.load_acc   = 1'b0;
      dp_cmd.add_term   = 1'b0;
      dp_cmd.finish     = FIN_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // The proportional product is started on the accepted sample itself.
               dp_cmd.capture = 1'b1;
               dp_cmd.mul_en  = 1'b1;
               dp_cmd.mul_sel = MUL_PROP;
               if (dp_status.limits_invalid) begin
                  fin_kind_in = FIN_INVALID;
                  state_in    = ST_FINISH;
               end else begin
                  priority if (req_operation == OP_UPDATE) begin
                     fin_kind_in = FIN_UPDATE;
                     state_in    = ST_MUL_I;
                  end else if (req_operation == OP_TRACK) begin
                     if (dp_status.windup_zero) begin
                        fin_kind_in = FIN_TRACK_SET;
                        state_in    = ST_FINISH;
                     end else begin
                        fin_kind_in = FIN_TRACK_ACC;
                        state_in    = ST_TRK_MUL;
                     end
                  end else if (req_operation == OP_RESET) begin
                     fin_kind_in = FIN_RESET;
                     state_in    = ST_FINISH;
                  end else begin
                     fin_kind_in = FIN_NOP;
                     state_in    = ST_FINISH;
                  end
               end
            end
         end
         ST_MUL_I: begin
            dp_cmd.mul_en    = 1'b1;
            dp_cmd.mul_sel   = MUL_INTEG;
            dp_cmd.latch_sum = 1'b1;
            dp_cmd.load_acc  = 1'b1;
            state_in         = ST_MUL_W;
         end
         ST_MUL_W: begin
            dp_cmd.mul_en   = 1'b1;
            dp_cmd.mul_sel  = MUL_WINDUP_UPD;
            dp_cmd.add_term = 1'b1;
            state_in        = ST_FINISH;
         end
         ST_TRK_MUL: begin
            dp_cmd.mul_en   = 1'b1;
            dp_cmd.mul_sel  = MUL_WINDUP_TRK;
            dp_cmd.load_acc = 1'b1;
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            // Retire only when the response register can take the result.
            if (out_free) begin
               dp_cmd.finish = fin_kind_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/pibcaw_datapath.sv =====
// Arithmetic datapath of the PI regulator: shared multiplier, integral, clamp
// and response registers. Uses pibcaw_pkg for command, status and code constants.
module pibcaw_datapath
   import pibcaw_pkg::*;
#(
   parameter int SIGNAL_WIDTH  = DEFAULT_SIGNAL_WIDTH,
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dp_cmd_type                     dp_cmd,
   output dp_status_type                  dp_status,
   input  logic signed [SIGNAL_WIDTH-1:0] req_sample,
   input  logic [GAIN_WIDTH-1:0]          prop_gain,
   input  logic [GAIN_WIDTH-1:0]          integral_step,
   input  logic [GAIN_WIDTH-1:0]          windup_step,
   input  logic signed [SIGNAL_WIDTH-1:0] limit_low,
   input  logic signed [SIGNAL_WIDTH-1:0] limit_high,
   output logic signed [SIGNAL_WIDTH-1:0] rsp_drive,
   output logic signed [RAW_WIDTH-1:0]    rsp_raw,
   output logic [STATUS_WIDTH-1:0]        rsp_status
);

   localparam int ACC_W   = SIGNAL_WIDTH + FRACTION_BITS + ACC_GUARD_BITS;
   localparam int DIFF_W  = SIGNAL_WIDTH + 11;
   localparam int PROD_W  = GAIN_WIDTH + 1 + DIFF_W;
   localparam int SUM_W   = ACC_W + 2;
   localparam int UNSAT_W = SUM_W - FRACTION_BITS;
   localparam int NEXT_W  = ACC_W + 4;
   localparam int KP_SHIFT = FRACTION_BITS - KP_FRAC_BITS;
   // Signed zero, so that limit comparisons against it stay signed.
   localparam logic signed [SIGNAL_WIDTH-1:0] ZERO_DRIVE = '0;

   logic signed [SIGNAL_WIDTH-1:0] x_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [UNSAT_W-1:0]      unsat_ff;
   logic signed [SIGNAL_WIDTH-1:0] lim_ff;
   logic signed [NEXT_W-1:0]       next_ff;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [SIGNAL_WIDTH-1:0] last_ff, last_in;
   logic signed [SIGNAL_WIDTH-1:0] drive_ff;
   logic signed [RAW_WIDTH-1:0]    raw_ff, raw_in;
   logic [STATUS_WIDTH-1:0]        status_ff, status_in;

   logic [GAIN_WIDTH-1:0]          mul_a;
   logic signed [DIFF_W-1:0]       mul_b;
   logic signed [PROD_W-1:0]       mul_p;
   logic signed [SUM_W-1:0]        p_ext, sum;
   logic signed [UNSAT_W-1:0]      unsat_now, low_ext, high_ext;
   logic signed [SIGNAL_WIDTH-1:0] lim_now, clamp_zero;
   logic signed [NEXT_W-1:0]       term, total;
   logic                           fits;

   assign dp_status.limits_invalid = limit_low >= limit_high;
   assign dp_status.windup_zero    = windup_step == '0;

   // Operand selection for the one multiplier shared by all three products.
   always_comb begin
      mul_a = prop_gain;
      mul_b = DIFF_W'(req_sample);
      unique case (dp_cmd.mul_sel)
         MUL_PROP: begin
            mul_a = prop_gain;
            mul_b = DIFF_W'(req_sample);
         end
         MUL_INTEG: begin
            mul_a = integral_step;
            mul_b = DIFF_W'(x_ff);
         end
         MUL_WINDUP_UPD: begin
            mul_a = windup_step;
            mul_b = DIFF_W'(lim_ff) - DIFF_W'(unsat_ff);
         end
         MUL_WINDUP_TRK: begin
            mul_a = windup_step;
            mul_b = DIFF_W'(x_ff) - DIFF_W'(last_ff);
         end
      endcase
   end

   assign mul_p = $signed({1'b0, mul_a}) * mul_b;

   // Proportional term plus integral; the unsaturated output is the floor of
   // the sum, which is simply its integer bits.
   assign p_ext     = SUM_W'(prod_ff) <<< KP_SHIFT;
   assign sum       = p_ext + SUM_W'(acc_ff);
   assign unsat_now = sum[SUM_W-1:FRACTION_BITS];
   assign low_ext   = UNSAT_W'(limit_low);
   assign high_ext  = UNSAT_W'(limit_high);

   always_comb begin
      if (unsat_now < low_ext) begin
         lim_now = limit_low;
      end else if (unsat_now > high_ext) begin
         lim_now = limit_high;
      end else begin
         lim_now = unsat_now[SIGNAL_WIDTH-1:0];
      end
   end

   always_comb begin
      if (limit_low > ZERO_DRIVE) begin
         clamp_zero = limit_low;
      end else if (limit_high < ZERO_DRIVE) begin
         clamp_zero = limit_high;
      end else begin
         clamp_zero = '0;
      end
   end

   // Q0.16 step products moved to the integral's fraction; a right shift
   // rounds toward minus infinity.
   generate
      if (FRACTION_BITS >= STEP_FRAC_BITS) begin : g_scale_up
         assign term = NEXT_W'(prod_ff) <<< (FRACTION_BITS - STEP_FRAC_BITS);
      end else begin : g_scale_down
         assign term = NEXT_W'(prod_ff >>> (STEP_FRAC_BITS - FRACTION_BITS));
      end
   endgenerate

   assign total = next_ff + term;
   assign fits  = (&total[NEXT_W-1:ACC_W-1]) || !(|total[NEXT_W-1:ACC_W-1]);

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         x_ff <= req_sample;
      end
      if (dp_cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (dp_cmd.latch_sum) begin
         unsat_ff <= unsat_now;
         lim_ff   <= lim_now;
      end
      if (dp_cmd.load_acc) begin
         next_ff <= NEXT_W'(acc_ff);
      end else if (dp_cmd.add_term) begin
         next_ff <= total;
      end
   end

   // Retirement: updates and nonzero-step tracks commit only when the integral fits.
   always_comb begin
      acc_in    = acc_ff;
      last_in   = last_ff;
      raw_in    = '0;
      status_in = STATUS_OK;
      unique case (dp_cmd.finish)
         FIN_UPDATE: begin
            if (fits) begin
               acc_in  = total[ACC_W-1:0];
               last_in = lim_ff;
               raw_in  = RAW_WIDTH'(unsat_ff);
            end else begin
               status_in = STATUS_OVERFLOW;
            end
         end
         FIN_TRACK_ACC: begin
            if (fits) begin
               acc_in  = total[ACC_W-1:0];
               last_in = x_ff;
            end else begin
               status_in = STATUS_OVERFLOW;
            end
         end
         FIN_TRACK_SET: begin
            last_in = x_ff;
         end
         FIN_RESET: begin
            acc_in  = '0;
            last_in = clamp_zero;
         end
         FIN_INVALID: begin
            status_in = STATUS_INVALID;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         last_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.finish != FIN_NONE) begin
         drive_ff  <= last_in;
         raw_ff    <= raw_in;
         status_ff <= status_in;
      end
   end

   assign rsp_drive  = drive_ff;
   assign rsp_raw    = raw_ff;
   assign rsp_status = status_ff;

endmodule

// ===== hdl/pi_back_calculation_antiwindup_core.sv =====
// Top level of the fixed-point PI regulator with back-calculation anti-windup.
// Depends on pibcaw_pkg, the channel interfaces, pibcaw_regs, pibcaw_ctrl and pibcaw_datapath.

// Each request is an update (the sample is the control error), a tracking request
// (the sample is the output actually applied) or a state reset, and produces exactly
// one response with the limited drive value, the unsaturated drive on a successful
// update and a status code. All three products share one 17 x (SIGNAL_WIDTH+11) bit
// multiplier with a register at its output. An update runs the proportional,
// integral and anti-windup products and then the integral commit; a tracking
// request with a nonzero anti-windup step runs its anti-windup product and then
// the commit, and every other request goes straight to its commit. The block takes
// one request at a time; a new request is accepted as soon as the previous one has
// reached the response register, even while that response still waits for rsp
// ready, and it then holds at its final step until the response register is free.
// When the limits are inconsistent (limit_low not below limit_high) or the new
// integral would leave its range, the state is left untouched and the status
// reports it. Write the configuration registers only while no request is in flight.
module pi_back_calculation_antiwindup_core
   import pibcaw_pkg::*;
#(
   parameter int SIGNAL_WIDTH  = DEFAULT_SIGNAL_WIDTH,
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS,
   parameter int CSR_DATA_W    = (SIGNAL_WIDTH > GAIN_WIDTH) ? SIGNAL_WIDTH : GAIN_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   pibcaw_req_if.sink             req_chan,
   pibcaw_rsp_if.source           rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [GAIN_WIDTH-1:0]          prop_gain;
   logic [GAIN_WIDTH-1:0]          integral_step;
   logic [GAIN_WIDTH-1:0]          windup_step;
   logic signed [SIGNAL_WIDTH-1:0] limit_low;
   logic signed [SIGNAL_WIDTH-1:0] limit_high;
   dp_cmd_type                     dp_cmd;
   dp_status_type                  dp_status;

   // Gains and limits, written through the plain CSR port.
   pibcaw_regs #(
      .SIGNAL_WIDTH (SIGNAL_WIDTH),
      .CSR_DATA_W   (CSR_DATA_W)
   ) u_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .prop_gain      (prop_gain),
      .integral_step  (integral_step),
      .windup_step    (windup_step),
      .limit_low      (limit_low),
      .limit_high     (limit_high)
   );

   // The controller owns both handshakes and schedules the shared multiplier.
   pibcaw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .dp_status     (dp_status),
      .dp_cmd        (dp_cmd)
   );

   // The datapath holds the integral, the last drive and the response payload.
   pibcaw_datapath #(
      .SIGNAL_WIDTH  (SIGNAL_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .dp_status     (dp_status),
      .req_sample    (req_chan.sample_value),
      .prop_gain     (prop_gain),
      .integral_step (integral_step),
      .windup_step   (windup_step),
      .limit_low     (limit_low),
      .limit_high    (limit_high),
      .rsp_drive     (rsp_chan.drive_value),
      .rsp_raw       (rsp_chan.raw_drive),
      .rsp_status    (rsp_chan.status)
   );

endmodule

// ===== verif/pi_back_calculation_antiwindup_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the fixed-point PI regulator core with back-calculation anti-windup.
// Depends on pibcaw_pkg, the request/response channel interfaces and the core itself.
import pibcaw_pkg::*;

typedef struct packed {
   logic signed [DEFAULT_SIGNAL_WIDTH-1:0] drive_value;
   logic signed [RAW_WIDTH-1:0]            raw_drive;
   logic [STATUS_WIDTH-1:0]                status;
} drive_answer_type;

// Keeps its own copy of the gains, limits, integral and last drive, works out the
// response of every accepted request, and checks responses in arrival order.
class drive_checker;
   longint           prop_gain, integral_step, windup_step, limit_low, limit_high;
   longint           integral_acc, last_drive;
   drive_answer_type awaited_drives[$];
   int               errors, checked;
   int               op_count[4];
   int               status_count[4];

   function new();
      prop_gain     = 0;
      integral_step = 0;
      windup_step   = 0;
      limit_low     = -(longint'(1) <<< (DEFAULT_SIGNAL_WIDTH - 1));
      limit_high    = (longint'(1) <<< (DEFAULT_SIGNAL_WIDTH - 1)) - 1;
      integral_acc  = 0;
      last_drive    = 0;
      errors        = 0;
      checked       = 0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
   endfunction

   function void set_register(logic [CSR_INDEX_W-1:0] index, logic [15:0] value);
      case (index)
         CSR_PROP_GAIN:     prop_gain = value;
         CSR_INTEGRAL_STEP: integral_step = value;
         CSR_WINDUP_STEP:   windup_step = value;
         CSR_LIMIT_LOW:     limit_low = longint'($signed(value));
         CSR_LIMIT_HIGH:    limit_high = longint'($signed(value));
         default: ;
      endcase
   endfunction

   function longint clamp_drive(longint v);
      if (v < limit_low) return limit_low;
      if (v > limit_high) return limit_high;
      return v;
   endfunction

   function void predict_drive(logic [OP_WIDTH-1:0] op,
                               logic signed [DEFAULT_SIGNAL_WIDTH-1:0] sample);
      longint           x, prop, unsat, lim, next, acc_top;
      drive_answer_type want;
      x = sample;
      acc_top = (longint'(1) <<< (DEFAULT_SIGNAL_WIDTH + DEFAULT_FRACTION_BITS
                                  + ACC_GUARD_BITS - 1)) - 1;
      want.raw_drive = '0;
      want.status    = STATUS_OK;
      op_count[op]++;
      if (limit_low >= limit_high) begin
         want.status = STATUS_INVALID;
      end else if (op == OP_UPDATE) begin
         prop  = (prop_gain * x) <<< (DEFAULT_FRACTION_BITS - KP_FRAC_BITS);
         unsat = (prop + integral_acc) >>> DEFAULT_FRACTION_BITS;
         lim   = clamp_drive(unsat);
         // The Q0.16 step products already carry as many fraction bits as the integral.
         next  = integral_acc + integral_step * x + windup_step * (lim - unsat);
         if (next > acc_top || next < -acc_top - 1) begin
            want.status = STATUS_OVERFLOW;
         end else begin
            integral_acc   = next;
            last_drive     = lim;
            want.raw_drive = unsat[RAW_WIDTH-1:0];
         end
      end else if (op == OP_TRACK) begin
         if (windup_step == 0) begin
            last_drive = x;
         end else begin
            next = integral_acc + windup_step * (x - last_drive);
            if (next > acc_top || next < -acc_top - 1) begin
               want.status = STATUS_OVERFLOW;
            end else begin
               integral_acc = next;
               last_drive   = x;
            end
         end
      end else if (op == OP_RESET) begin
         integral_acc = 0;
         last_drive   = clamp_drive(0);
      end
      want.drive_value = last_drive[DEFAULT_SIGNAL_WIDTH-1:0];
      status_count[want.status]++;
      awaited_drives.push_back(want);
   endfunction

   function void check_response(logic signed [DEFAULT_SIGNAL_WIDTH-1:0] drive,
                                logic signed [RAW_WIDTH-1:0] raw,
                                logic [STATUS_WIDTH-1:0] status);
      drive_answer_type want;
      if (awaited_drives.size() == 0) begin
         errors++;
         $display("%0t: unexpected response drive_value %0d raw_drive %0d status %0d",
                  $time, drive, raw, status);
         return;
      end
      want = awaited_drives.pop_front();
      checked++;
      if (drive !== want.drive_value) begin
         errors++;
         $display("%0t: drive_value expected %0d, got %0d", $time, want.drive_value, drive);
      end
      if (raw !== want.raw_drive) begin
         errors++;
         $display("%0t: raw_drive expected %0d, got %0d", $time, want.raw_drive, raw);
      end
      if (status !== want.status) begin
         errors++;
         $display("%0t: status expected %0d, got %0d", $time, want.status, status);
      end
   endfunction
endclass

module pi_back_calculation_antiwindup_core_tb;

   localparam int SW = DEFAULT_SIGNAL_WIDTH;
   localparam int FB = DEFAULT_FRACTION_BITS;

   // The operation code that the core must treat as a no-op.
   localparam logic [OP_WIDTH-1:0] OP_UNKNOWN = 2'd3;

   localparam logic signed [SW-1:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [SW-1:0] SAMPLE_MAX = 16'sh7FFF;

   localparam int RESET_CYCLES     = 7;
   // Settling wait after the last response, before the registers are touched.
   localparam int SETTLE_CYCLES    = 4;
   localparam int END_CYCLES       = 16;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int RANDOM_PHASES    = 12;
   localparam int ITEMS_PER_PHASE  = 50;
   // Phase in which the sender stops halfway and lets the core drain completely.
   localparam int PAUSE_PHASE      = 7;
   // The receiver holds off once, after this many responses, for this many cycles.
   localparam int HOLD_AFTER       = 150;
   localparam int LONG_HOLD_CYCLES = 300;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [15:0]            csr_write_data;

   pibcaw_req_if #(.SIGNAL_WIDTH(SW)) req_chan ();
   pibcaw_rsp_if #(.SIGNAL_WIDTH(SW)) rsp_chan ();

   drive_checker board;
   bit           sender_steady = 1'b0;
   bit           long_hold_done = 1'b0;
   int           idle_cycles = 0;

   pi_back_calculation_antiwindup_core #(
      .SIGNAL_WIDTH  (SW),
      .FRACTION_BITS (FB)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gains are drawn from zero, full scale, small values, values around unity and
   // anything else, so that both tiny and huge products show up.
   function automatic logic [15:0] random_gain();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 255));
         3: return 16'($urandom_range(256, 4095));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [SW-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3: return 16'($urandom_range(0, 128) - 64);
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one. A steady stretch
   // never idles at all.
   function automatic int idle_gap(bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offers one request and waits for the handshake. Valid stays high into the next
   // request when no gap follows, so it is never lowered and raised in one step.
   task automatic send_request(input logic [OP_WIDTH-1:0] op, input logic signed [SW-1:0] value);
      int gap;
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.sample_value <= value;
      do @(posedge clock); while (!req_chan.ready);
      board.predict_drive(op, value);
      gap = idle_gap(sender_steady);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering requests and waits until every predicted response has come back
   // and the core has had time to go idle.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (board.awaited_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all five registers back to back. The core must be idle, so the task
   // drains it first.
   task automatic load_settings(input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] aw, input logic [15:0] lo,
                                input logic [15:0] hi);
      logic [CSR_INDEX_W-1:0] regs [5];
      logic [15:0]            values [5];
      regs   = '{CSR_PROP_GAIN, CSR_INTEGRAL_STEP, CSR_WINDUP_STEP, CSR_LIMIT_LOW,
                 CSR_LIMIT_HIGH};
      values = '{kp, ki, aw, lo, hi};
      wait_drained();
      csr_write_en <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_index      <= regs[i];
         csr_write_data <= values[i];
         @(posedge clock);
         board.set_register(regs[i], values[i]);
      end
      csr_write_en <= 1'b0;
   endtask

   // Response side: random ready gaps, steady stretches, and one long hold-off while
   // the sender keeps pushing, which fills the core and stalls its request port.
   initial begin
      int gap;
      bit ready_steady;
      ready_steady = 1'b0;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && board.checked >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            gap = LONG_HOLD_CYCLES;
         end else begin
            gap = idle_gap(ready_steady);
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         board.check_response(rsp_chan.drive_value, rsp_chan.raw_drive, rsp_chan.status);
         if ($urandom_range(0, 39) == 0) ready_steady = !ready_steady;
      end
   end

   // Watchdog: any stretch this long without a single handshake means the core hung.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("pi_back_calculation_antiwindup_core_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                   phase, sent, pick, center;
      logic [15:0]          kp, ki, aw;
      logic signed [SW-1:0] lo, hi, value;
      logic [OP_WIDTH-1:0]  op;

      board = new();
      req_chan.valid        <= 1'b0;
      req_chan.operation    <= OP_UPDATE;
      req_chan.sample_value <= '0;
      csr_write_en          <= 1'b0;
      csr_index             <= CSR_PROP_GAIN;
      csr_write_data        <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero gains and the full output range. Tracking with a zero
      // anti-windup step only takes the applied value, and the unknown operation
      // must answer with the last drive and change nothing.
      send_request(OP_UPDATE, SAMPLE_MAX);
      send_request(OP_UPDATE, SAMPLE_MIN);
      send_request(OP_TRACK, 16'sd12345);
      send_request(OP_UNKNOWN, SAMPLE_MIN);
      send_request(OP_RESET, SAMPLE_MAX);
      send_request(OP_TRACK, SAMPLE_MIN);

      // Full-scale proportional and anti-windup gains with the limits pinned at the
      // bottom: the first update's back-calculation term runs the integral out of
      // range. The full-scale tracking value overflows as well, and a tracking value
      // above the upper limit is then taken unclamped.
      load_settings(16'hFFFF, 16'h0000, 16'hFFFF, SAMPLE_MIN, SAMPLE_MIN + 16'sd1);
      send_request(OP_UPDATE, SAMPLE_MAX);
      send_request(OP_UPDATE, SAMPLE_MIN);
      send_request(OP_TRACK, SAMPLE_MAX);
      send_request(OP_TRACK, -16'sd100);
      send_request(OP_RESET, 16'sd0);

      // Reversed limits: every operation, reset included, must leave the state alone.
      load_settings(16'h0100, 16'h8000, 16'h0000, 16'sd100, -16'sd100);
      send_request(OP_UPDATE, 16'sd1000);
      send_request(OP_RESET, 16'sd0);
      send_request(OP_UNKNOWN, 16'sd0);

      // Moving the limits to the top must not move the last drive by itself; the
      // no-op shows the old value before the first update clamps to the new range.
      load_settings(16'h0100, 16'h8000, 16'h0000, SAMPLE_MAX - 16'sd1, SAMPLE_MAX);
      send_request(OP_UNKNOWN, 16'sd7);
      send_request(OP_UPDATE, 16'sd0);
      send_request(OP_UPDATE, SAMPLE_MIN);
      send_request(OP_TRACK, SAMPLE_MAX);
      send_request(OP_TRACK, SAMPLE_MIN);

      // Limits at the top and a full negative error: the mirror overflow case.
      load_settings(16'hFFFF, 16'h0000, 16'hFFFF, SAMPLE_MAX - 16'sd1, SAMPLE_MAX);
      send_request(OP_UPDATE, SAMPLE_MIN);
      send_request(OP_UPDATE, SAMPLE_MAX);
      send_request(OP_RESET, SAMPLE_MIN);

      // Random phases. Each one picks new gains and a limit window (full range,
      // pinned near either rail, narrow, around zero, random, equal or reversed) and then runs a
      // stream of requests against it. Tracking values often sit close to the last
      // drive, as a real actuator would report them.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         kp = random_gain();
         ki = random_gain();
         aw = random_gain();
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               lo = SAMPLE_MIN;
               hi = SAMPLE_MAX;
            end
            1: begin
               hi = SAMPLE_MAX - 16'($urandom_range(0, 3));
               lo = hi - 16'($urandom_range(1, 200));
            end
            2: begin
               lo = SAMPLE_MIN + 16'($urandom_range(0, 3));
               hi = lo + 16'($urandom_range(1, 200));
            end
            3, 4: begin
               center = int'($urandom_range(0, 4000)) - 2000;
               lo = 16'(center - int'($urandom_range(1, 300)));
               hi = 16'(center + int'($urandom_range(1, 300)));
            end
            5, 6: begin
               lo = 16'($urandom);
               hi = 16'($urandom);
               if (lo > hi) begin
                  value = lo;
                  lo = hi;
                  hi = value;
               end
            end
            7: begin
               lo = 16'(-int'($urandom_range(1, 1000)));
               hi = 16'($urandom_range(1, 1000));
            end
            8: begin
               lo = 16'($urandom);
               hi = lo;
            end
            default: begin
               lo = 16'($urandom_range(0, 32767));
               hi = 16'(-int'($urandom_range(0, 32768)));
            end
         endcase
         load_settings(kp, ki, aw, lo, hi);
         sender_steady = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) op = OP_UPDATE;
            else if (pick < 82) op = OP_TRACK;
            else if (pick < 93) op = OP_RESET;
            else op = OP_UNKNOWN;
            if (op == OP_TRACK && $urandom_range(0, 1) == 1)
               value = 16'(board.last_drive + int'($urandom_range(0, 64)) - 32);
            else
               value = random_sample();
            send_request(op, value);
            if (op != OP_UNKNOWN) sent++;
            // Halfway through one phase the sender goes quiet until the core is empty.
            if (phase == PAUSE_PHASE && sent == ITEMS_PER_PHASE / 2) wait_drained();
         end
      end

      sender_steady = 1'b0;
      wait_drained();
      repeat (END_CYCLES) @(posedge clock);

      $display("Covered %0d updates, %0d tracking, %0d resets and %0d no-op requests.",
               board.op_count[OP_UPDATE], board.op_count[OP_TRACK],
               board.op_count[OP_RESET], board.op_count[OP_UNKNOWN]);
      $display("Checked %0d responses, %0d overflows and %0d invalid limits; %0d mismatches.",
               board.checked, board.status_count[STATUS_OVERFLOW],
               board.status_count[STATUS_INVALID], board.errors);
      if (board.errors == 0)
         $display("pi_back_calculation_antiwindup_core_tb: done, clean");
      else
         $display("pi_back_calculation_antiwindup_core_tb: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/pibcaw_pkg.sv
hdl/pibcaw_if.sv
hdl/pibcaw_regs.sv
hdl/pibcaw_ctrl.sv
hdl/pibcaw_datapath.sv
hdl/pi_back_calculation_antiwindup_core.sv
verif/pi_back_calculation_antiwindup_core_tb.sv
